// ----- src/dcmdt_pkg.sv -----
`timescale 1ns / 1ps

package dcmdt_pkg;

  localparam int DUTY_W   = 18;
  localparam int GAIN_W   = 24;
  localparam int LIMIT_W  = 26;
  localparam int Q_W      = 32;
  localparam int MATCH_W  = 8;
  localparam int IDX_W    = 3;
  localparam int CFG_D_W  = 26;
  localparam int IN_W     = 128;

  localparam logic signed [DUTY_W-1:0] DUTY_MAX  = 18'sd65536;
  localparam logic signed [DUTY_W-1:0] DUTY_MIN  = -18'sd65536;
  localparam logic signed [DUTY_W-1:0] COAST_MAX = 18'sd65;
  localparam logic signed [DUTY_W-1:0] COAST_MIN = -18'sd65;

  localparam logic [MATCH_W-1:0] MATCH_OFF_A = 8'd0;
  localparam logic [MATCH_W-1:0] MATCH_OFF_B = 8'd4;

  typedef enum logic [IDX_W-1:0] {
    CFG_KP      = 3'd0,
    CFG_KD      = 3'd1,
    CFG_BACKEMF = 3'd2,
    CFG_COND    = 3'd3,
    CFG_TGAIN   = 3'd4,
    CFG_ILIMIT  = 3'd5,
    CFG_MODE    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  kd;
    logic [GAIN_W-1:0]  backemf;
    logic [GAIN_W-1:0]  conductance;
    logic [GAIN_W-1:0]  torque_gain;
    logic [LIMIT_W-1:0] current_limit;
    logic               brake;
    logic               inverted;
    logic               position_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    kp:            24'd6554,
    kd:            24'd655,
    backemf:       24'd1245,
    conductance:   24'd1998848,
    torque_gain:   24'd1270,
    current_limit: 26'd0,
    brake:         1'b0,
    inverted:      1'b0,
    position_mode: 1'b0
  };

endpackage

// ----- src/dcmdt_duty.sv -----
`timescale 1ns / 1ps

module dcmdt_duty (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dcmdt_pkg::cfg_t                      cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [dcmdt_pkg::Q_W-1:0]     vel_i,
  input  logic signed [dcmdt_pkg::Q_W-1:0]     pos_i,
  input  logic signed [dcmdt_pkg::DUTY_W-1:0]  cmd_i,
  input  logic signed [dcmdt_pkg::Q_W-1:0]     setp_i,
  input  logic        [dcmdt_pkg::MATCH_W-1:0] match_i,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dcmdt_pkg::DUTY_W-1:0]  duty_o,
  output logic signed [dcmdt_pkg::Q_W-1:0]     vel_o
);
  import dcmdt_pkg::*;

  localparam int ERR_W = Q_W + 1;
  localparam int ACC_W = ERR_W + GAIN_W + 1;
  localparam int PD_W  = ACC_W - 16;

  logic [3:0] vld_r;
  logic [3:0] adv;

  // stage 1: position error, command clamp
  logic signed [ERR_W-1:0]  err_nxt, err1_r;
  logic signed [DUTY_W-1:0] cmdc_nxt, cmdc1_r, cmdc2_r, cmdc3_r;
  logic                     off_nxt, off1_r, off2_r, off3_r;
  logic signed [Q_W-1:0]    vel1_r, vel2_r, vel3_r, vel4_r;
  // stage 2: gain products
  logic signed [GAIN_W:0]   kp_s, kd_s;
  logic signed [ACC_W-1:0]  kp_nxt, kd_nxt, kp2_r, kd2_r;
  // stage 3: pd sum
  logic signed [ACC_W-1:0]  acc_nxt, acc3_r;
  // stage 4: duty select
  logic signed [PD_W-1:0]   pd_raw;
  logic signed [DUTY_W-1:0] pd_clamp, duty_sel, duty_nxt, duty4_r;

  always_comb begin
    adv[3] = !vld_r[3] || out_ready;
    adv[2] = !vld_r[2] || adv[3];
    adv[1] = !vld_r[1] || adv[2];
    adv[0] = !vld_r[0] || adv[1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
      if (adv[3]) vld_r[3] <= vld_r[2];
    end
  end

  always_comb begin
    err_nxt = ERR_W'(setp_i) - ERR_W'(pos_i);
    priority if (cmd_i > DUTY_MAX) cmdc_nxt = DUTY_MAX;
    else if (cmd_i < DUTY_MIN)     cmdc_nxt = DUTY_MIN;
    else                           cmdc_nxt = cmd_i;
    off_nxt = (match_i == MATCH_OFF_A) || (match_i == MATCH_OFF_B);
  end

  assign kp_s   = $signed({1'b0, cfg.kp});
  assign kd_s   = $signed({1'b0, cfg.kd});
  assign kp_nxt = ACC_W'(kp_s) * ACC_W'(err1_r);
  assign kd_nxt = ACC_W'(kd_s) * ACC_W'(vel1_r);
  assign acc_nxt = kp2_r - kd2_r;

  always_comb begin
    pd_raw = acc3_r[ACC_W-1:16];
    priority if (pd_raw > PD_W'(DUTY_MAX)) pd_clamp = DUTY_MAX;
    else if (pd_raw < PD_W'(DUTY_MIN))     pd_clamp = DUTY_MIN;
    else                                   pd_clamp = pd_raw[DUTY_W-1:0];
    duty_sel = cfg.position_mode ? pd_clamp : cmdc3_r;
    if (off3_r) duty_sel = '0;
    // clamp is symmetric, so negating after it matches negating before
    duty_nxt = cfg.inverted ? -duty_sel : duty_sel;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      err1_r  <= err_nxt;
      cmdc1_r <= cmdc_nxt;
      off1_r  <= off_nxt;
      vel1_r  <= vel_i;
    end
    if (adv[1]) begin
      kp2_r   <= kp_nxt;
      kd2_r   <= kd_nxt;
      cmdc2_r <= cmdc1_r;
      off2_r  <= off1_r;
      vel2_r  <= vel1_r;
    end
    if (adv[2]) begin
      acc3_r  <= acc_nxt;
      cmdc3_r <= cmdc2_r;
      off3_r  <= off2_r;
      vel3_r  <= vel2_r;
    end
    if (adv[3]) begin
      duty4_r <= duty_nxt;
      vel4_r  <= vel3_r;
    end
  end

  assign duty_o = duty4_r;
  assign vel_o  = vel4_r;

endmodule

// ----- src/dcmdt_current.sv -----
`timescale 1ns / 1ps

module dcmdt_current (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dcmdt_pkg::cfg_t                     cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dcmdt_pkg::DUTY_W-1:0] duty_i,
  input  logic signed [dcmdt_pkg::Q_W-1:0]    vel_i,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [49:0]                  cur_o,
  output logic                                zero_o
);
  import dcmdt_pkg::*;

  localparam int BE_W    = Q_W + GAIN_W + 1;
  localparam int DIFF_W  = BE_W + 1;
  localparam int D16_W   = DIFF_W - 16;
  localparam int LO_W    = 17;
  localparam int HI_W    = D16_W - LO_W;
  localparam int PHI_W   = HI_W + GAIN_W + 1;
  localparam int PLO_W   = LO_W + GAIN_W + 2;
  localparam int FULL_W  = D16_W + GAIN_W;
  localparam int CUR_W   = FULL_W - 16;
  localparam int V12_W   = DUTY_W + 4;
  localparam int VOLTS_W = V12_W + 16;

  logic [3:0] vld_r;
  logic [3:0] adv;

  logic signed [GAIN_W:0]   be_s, cond_s;
  logic signed [BE_W-1:0]   be_nxt, be1_r;
  logic signed [DUTY_W-1:0] duty1_r;
  logic                     zero_nxt, zero1_r, zero2_r, zero3_r, zero4_r;
  logic signed [V12_W-1:0]  d_ext, duty12;
  logic signed [VOLTS_W-1:0] volts;
  logic signed [DIFF_W-1:0] diff;
  logic signed [D16_W-1:0]  diff2_r;
  logic signed [HI_W-1:0]   d_hi;
  logic signed [LO_W:0]     d_lo;
  logic signed [PHI_W-1:0]  phi_nxt, phi3_r;
  logic signed [PLO_W-1:0]  plo_nxt, plo3_r;
  logic signed [FULL_W-1:0] full;
  logic signed [CUR_W-1:0]  cur4_r;

  always_comb begin
    adv[3] = !vld_r[3] || out_ready;
    adv[2] = !vld_r[2] || adv[3];
    adv[1] = !vld_r[1] || adv[2];
    adv[0] = !vld_r[0] || adv[1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
      if (adv[3]) vld_r[3] <= vld_r[2];
    end
  end

  // stage 1: back-emf product, coast decision
  assign be_s     = $signed({1'b0, cfg.backemf});
  assign be_nxt   = BE_W'(be_s) * BE_W'(vel_i);
  assign zero_nxt = !cfg.brake && (duty_i >= COAST_MIN) && (duty_i <= COAST_MAX);

  // stage 2: 12 * duty at q.32 minus back-emf, floored to q.16
  always_comb begin
    d_ext  = V12_W'(duty1_r);
    duty12 = (d_ext <<< 3) + (d_ext <<< 2);
    volts  = $signed({duty12, 16'h0000});
    diff   = DIFF_W'(volts) - DIFF_W'(be1_r);
  end

  // stage 3: split conductance product
  assign cond_s  = $signed({1'b0, cfg.conductance});
  assign d_hi    = diff2_r[D16_W-1:LO_W];
  assign d_lo    = $signed({1'b0, diff2_r[LO_W-1:0]});
  assign phi_nxt = PHI_W'(d_hi) * PHI_W'(cond_s);
  assign plo_nxt = PLO_W'(d_lo) * PLO_W'(cond_s);

  // stage 4: recombine and floor
  assign full = (FULL_W'(phi3_r) <<< LO_W) + FULL_W'(plo3_r);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      be1_r   <= be_nxt;
      duty1_r <= duty_i;
      zero1_r <= zero_nxt;
    end
    if (adv[1]) begin
      diff2_r <= diff[DIFF_W-1:16];
      zero2_r <= zero1_r;
    end
    if (adv[2]) begin
      phi3_r  <= phi_nxt;
      plo3_r  <= plo_nxt;
      zero3_r <= zero2_r;
    end
    if (adv[3]) begin
      cur4_r  <= full[FULL_W-1:16];
      zero4_r <= zero3_r;
    end
  end

  assign cur_o  = cur4_r;
  assign zero_o = zero4_r;

endmodule

// ----- src/dcmdt_torque.sv -----
`timescale 1ns / 1ps

module dcmdt_torque (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dcmdt_pkg::cfg_t                  cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [49:0]               cur_i,
  input  logic                             zero_i,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dcmdt_pkg::Q_W-1:0] torque_o
);
  import dcmdt_pkg::*;

  localparam int CUR_W  = 50;
  localparam int LO_W   = 17;
  localparam int HI_W   = CUR_W - LO_W;
  localparam int PHI_W  = HI_W + GAIN_W + 1;
  localparam int PLO_W  = LO_W + GAIN_W + 2;
  localparam int FULL_W = CUR_W + GAIN_W;
  localparam int TRQ_W  = FULL_W - 16;

  localparam logic signed [TRQ_W-1:0] TRQ_MAX = TRQ_W'(64'sd2147483647);
  localparam logic signed [TRQ_W-1:0] TRQ_MIN = TRQ_W'(-64'sd2147483648);

  logic [3:0] vld_r;
  logic [3:0] adv;

  logic signed [CUR_W-1:0]  lim, curl_nxt, curl1_r;
  logic                     zero1_r, zero2_r, zero3_r;
  logic signed [GAIN_W:0]   tg_s;
  logic signed [HI_W-1:0]   c_hi;
  logic signed [LO_W:0]     c_lo;
  logic signed [PHI_W-1:0]  phi_nxt, phi2_r;
  logic signed [PLO_W-1:0]  plo_nxt, plo2_r;
  logic signed [FULL_W-1:0] full;
  logic signed [TRQ_W-1:0]  trq3_r;
  logic signed [Q_W-1:0]    sat_nxt, trq4_r;

  always_comb begin
    adv[3] = !vld_r[3] || out_ready;
    adv[2] = !vld_r[2] || adv[3];
    adv[1] = !vld_r[1] || adv[2];
    adv[0] = !vld_r[0] || adv[1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
      if (adv[3]) vld_r[3] <= vld_r[2];
    end
  end

  // stage 1: current limit, zero limit leaves the current alone
  always_comb begin
    lim = $signed({{(CUR_W-LIMIT_W){1'b0}}, cfg.current_limit});
    curl_nxt = cur_i;
    if (cfg.current_limit != '0) begin
      priority if (cur_i > lim) curl_nxt = lim;
      else if (cur_i < -lim)    curl_nxt = -lim;
      else                      curl_nxt = cur_i;
    end
  end

  // stage 2: split torque gain product
  assign tg_s    = $signed({1'b0, cfg.torque_gain});
  assign c_hi    = curl1_r[CUR_W-1:LO_W];
  assign c_lo    = $signed({1'b0, curl1_r[LO_W-1:0]});
  assign phi_nxt = PHI_W'(c_hi) * PHI_W'(tg_s);
  assign plo_nxt = PLO_W'(c_lo) * PLO_W'(tg_s);

  // stage 3: recombine and floor
  assign full = (FULL_W'(phi2_r) <<< LO_W) + FULL_W'(plo2_r);

  // stage 4: saturate, coast forces zero
  always_comb begin
    priority if (zero3_r)    sat_nxt = '0;
    else if (trq3_r > TRQ_MAX) sat_nxt = TRQ_MAX[Q_W-1:0];
    else if (trq3_r < TRQ_MIN) sat_nxt = TRQ_MIN[Q_W-1:0];
    else                       sat_nxt = trq3_r[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      curl1_r <= curl_nxt;
      zero1_r <= zero_i;
    end
    if (adv[1]) begin
      phi2_r  <= phi_nxt;
      plo2_r  <= plo_nxt;
      zero2_r <= zero1_r;
    end
    if (adv[2]) begin
      trq3_r  <= full[FULL_W-1:16];
      zero3_r <= zero2_r;
    end
    if (adv[3]) begin
      trq4_r  <= sat_nxt;
    end
  end

  assign torque_o = trq4_r;

endmodule

// ----- src/dc_motor_drive_torque_unit.sv -----
// throughput: one beat per cycle while out_tready is high, set by the 12 register
//   stages that each advance on their own valid bit; bubbles close up while the
//   output is stalled
// reset: rst_n synchronous, active low; empties the pipeline and loads the
//   default motor constants into the configuration registers
`timescale 1ns / 1ps

module dc_motor_drive_torque_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write channel, always ready
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dcmdt_pkg::IDX_W-1:0]        cfg_index,
  input  logic [dcmdt_pkg::CFG_D_W-1:0]      cfg_data,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // joint_velocity [31:0], joint_position [63:32], duty_command [81:64],
  // position_setpoint [113:82], match_state [121:114], zero fill [127:122]
  input  logic [dcmdt_pkg::IN_W-1:0]         in_tdata,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // joint_torque [31:0]
  output logic [dcmdt_pkg::Q_W-1:0]          out_tdata
);
  import dcmdt_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // duty stage group to current stage group
  logic                     duty_vld, duty_rdy;
  logic signed [DUTY_W-1:0] duty;
  logic signed [Q_W-1:0]    duty_vel;
  // current stage group to torque stage group
  logic                     cur_vld, cur_rdy;
  logic signed [49:0]       cur;
  logic                     cur_zero;
  logic signed [Q_W-1:0]    torque;

  assign cfg_ready = 1'b1;

  // configuration registers, unknown index is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KP:      cfg_nxt.kp            = cfg_data[GAIN_W-1:0];
        CFG_KD:      cfg_nxt.kd            = cfg_data[GAIN_W-1:0];
        CFG_BACKEMF: cfg_nxt.backemf       = cfg_data[GAIN_W-1:0];
        CFG_COND:    cfg_nxt.conductance   = cfg_data[GAIN_W-1:0];
        CFG_TGAIN:   cfg_nxt.torque_gain   = cfg_data[GAIN_W-1:0];
        CFG_ILIMIT:  cfg_nxt.current_limit = cfg_data[LIMIT_W-1:0];
        CFG_MODE: begin
          cfg_nxt.position_mode = cfg_data[0];
          cfg_nxt.inverted      = cfg_data[1];
          cfg_nxt.brake         = cfg_data[2];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stages 1-4: position error, pd products, duty select, invert and clamp
  dcmdt_duty u_duty (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .vel_i     ($signed(in_tdata[31:0])),
    .pos_i     ($signed(in_tdata[63:32])),
    .cmd_i     ($signed(in_tdata[81:64])),
    .setp_i    ($signed(in_tdata[113:82])),
    .match_i   (in_tdata[121:114]),
    .out_valid (duty_vld),
    .out_ready (duty_rdy),
    .duty_o    (duty),
    .vel_o     (duty_vel)
  );

  // stages 5-8: back-emf, voltage difference, winding current
  dcmdt_current u_current (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (duty_vld),
    .in_ready  (duty_rdy),
    .duty_i    (duty),
    .vel_i     (duty_vel),
    .out_valid (cur_vld),
    .out_ready (cur_rdy),
    .cur_o     (cur),
    .zero_o    (cur_zero)
  );

  // stages 9-12: current limit, torque product, saturation into the output register
  dcmdt_torque u_torque (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (cur_vld),
    .in_ready  (cur_rdy),
    .cur_i     (cur),
    .zero_i    (cur_zero),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .torque_o  (torque)
  );

  assign out_tdata = torque;

  // an open sink never backs up into the source
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while result side is ready");

  // an empty output register lets every stage move
  a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result beat right after reset");

endmodule
